[rtl/nonce_challenge_rate_limited_defines.svh]
// ----------------------------------------------------------------------------
// nonce challenge engine assertion macros
// shared property wrappers for the assertion checker
// ----------------------------------------------------------------------------
`ifndef NONCE_CHALLENGE_RATE_LIMITED_DEFINES_SVH
`define NONCE_CHALLENGE_RATE_LIMITED_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define NC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nc_pkg.sv]
// ----------------------------------------------------------------------------
// nc_pkg
// types, constants and helpers of the nonce challenge engine
// ----------------------------------------------------------------------------
`default_nettype none

package nc_pkg;

  localparam int NONCE_BYTES = 8;
  localparam int NONCE_BITS  = 8 * NONCE_BYTES;
  localparam int NCHARS      = 2 * NONCE_BYTES;
  localparam int CNT_W       = $clog2(NCHARS + 1);
  localparam int SEC_W       = 32;
  localparam int RAND_W      = 64;

  localparam logic [CNT_W-1:0] NCHARS_C = CNT_W'(NCHARS);
  localparam logic [SEC_W-1:0] SEC_MAX  = {SEC_W{1'b1}};

  // input modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ISSUE = 2'd1;
  localparam logic [1:0] MODE_ECHO  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REFUSED  = 3'd1;
  localparam logic [2:0] ST_RND_FAIL = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_EXPIRED  = 3'd4;

  // config register indexes
  localparam logic CFG_MIN_INTERVAL = 1'b0;
  localparam logic CFG_TIMEOUT      = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [RAND_W-1:0] random_value;
    logic              random_ok;
    logic [7:0]        echo_char;
    logic              echo_last;
  } nc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] hex_char;
    logic       char_valid;
    logic       last;
  } nc_out_t;

  // top -> emitter
  typedef struct packed {
    logic                  load;
    logic                  single;
    logic [2:0]            status;
    logic [NONCE_BITS-1:0] nonce;
  } nc_emit_req_t;

  // emitter -> top
  typedef struct packed {
    logic busy;
    logic free;
  } nc_emit_st_t;

  // top -> checker
  typedef struct packed {
    logic                  load;
    logic                  echo;
    logic                  last;
    logic [7:0]            echo_char;
    logic [NONCE_BITS-1:0] nonce;
  } nc_chk_req_t;

  function automatic logic [6:0] nib_to_hex(input logic [3:0] nib);
    logic [6:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) return 7'h30 + n7;
    else             return 7'h57 + n7;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_to_nib(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b00000;
  endfunction

endpackage

`default_nettype wire

[rtl/nonce_challenge_rate_limited.sv]
// ----------------------------------------------------------------------------
// nonce_challenge_rate_limited
// rate limited challenge-response nonce engine
// ----------------------------------------------------------------------------
// usage:
//   in_* carries ticks, issue requests and echoed characters, one per beat;
//   out_* carries results through a single output register.
//   a tick, an echo without last and an unused mode give no result. a
//   refused issue, an issue with random_ok low or a final echo gives one
//   result beat, in the output register the cycle after acceptance. an
//   accepted issue streams 2*NONCE_BYTES hex beats from the nibble shift
//   register via the output register, one per cycle while not stalled;
//   in_ready stays low until the last character is in the output register.
//   in_ready also drops while a result waits and out_ready is low; a stalled
//   output holds its beat and the character stream pauses with it.
//   synchronous reset clears pending state, the seconds counter, the echo
//   collector and the output valid flag, and loads min_interval 0, timeout 60.
//   cfg_we writes a register (index 0 min_interval, 1 timeout) at once.
// ----------------------------------------------------------------------------
`default_nettype none

module nonce_challenge_rate_limited (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire nc_pkg::nc_in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output nc_pkg::nc_out_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [31:0]     cfg_wdata
);
  import nc_pkg::*;

  logic [SEC_W-1:0] min_interval_r, timeout_r;
  logic [SEC_W-1:0] secs_r, secs_nxt;
  logic             pending_r, pending_nxt;
  logic             ever_r, ever_nxt;

  nc_emit_req_t emit_req;
  nc_emit_st_t  emit_st;
  nc_chk_req_t  chk_req;
  logic         chk_fail;

  logic accept, is_tick, is_issue, is_echo;
  logic refuse, issue_ok, echo_end;

  assign in_ready = !emit_st.busy && emit_st.free;
  assign accept   = in_valid && in_ready;
  assign is_tick  = accept && (in_data.mode == MODE_TICK);
  assign is_issue = accept && (in_data.mode == MODE_ISSUE);
  assign is_echo  = accept && (in_data.mode == MODE_ECHO);

  assign refuse   = pending_r || (ever_r && (secs_r < min_interval_r));
  assign issue_ok = is_issue && !refuse && in_data.random_ok;
  assign echo_end = is_echo && in_data.echo_last;

  always_comb begin
    emit_req.load   = issue_ok;
    emit_req.single = (is_issue && !issue_ok) || echo_end;
    emit_req.nonce  = in_data.random_value[NONCE_BITS-1:0];
    if (is_issue) begin
      emit_req.status = refuse ? ST_REFUSED : ST_RND_FAIL;
    end else if (!pending_r) begin
      emit_req.status = ST_MISMATCH;
    end else if (secs_r >= timeout_r) begin
      emit_req.status = ST_EXPIRED;
    end else if (chk_fail) begin
      emit_req.status = ST_MISMATCH;
    end else begin
      emit_req.status = ST_OK;
    end
  end

  always_comb begin
    chk_req.load      = issue_ok;
    chk_req.echo      = is_echo;
    chk_req.last      = in_data.echo_last;
    chk_req.echo_char = in_data.echo_char;
    chk_req.nonce     = in_data.random_value[NONCE_BITS-1:0];
  end

  always_comb begin
    secs_nxt    = secs_r;
    pending_nxt = pending_r;
    ever_nxt    = ever_r;
    if (is_tick && secs_r != SEC_MAX) begin
      secs_nxt = secs_r + SEC_W'(1);
    end
    if (issue_ok) begin
      secs_nxt    = '0;
      pending_nxt = 1'b1;
      ever_nxt    = 1'b1;
    end
    if (echo_end) begin
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= '0;
      timeout_r      <= SEC_W'(60);
      secs_r         <= '0;
      pending_r      <= 1'b0;
      ever_r         <= 1'b0;
    end else begin
      secs_r    <= secs_nxt;
      pending_r <= pending_nxt;
      ever_r    <= ever_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
          CFG_TIMEOUT:      timeout_r      <= cfg_wdata;
          default:          min_interval_r <= min_interval_r;
        endcase
      end
    end
  end

  nc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit_req),
    .st        (emit_st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  nc_check u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (chk_req),
    .fail  (chk_fail)
  );

endmodule

`default_nettype wire

[rtl/nc_emit.sv]
// ----------------------------------------------------------------------------
// nc_emit
// nibble shift register that streams the nonce as hex, plus the output register
// ----------------------------------------------------------------------------
`default_nettype none

module nc_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nc_pkg::nc_emit_req_t req,
  output nc_pkg::nc_emit_st_t       st,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output nc_pkg::nc_out_t           out_data
);
  import nc_pkg::*;

  logic [NONCE_BITS-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  nc_out_t               out_data_r, out_data_nxt;
  logic                  free;

  always_comb begin
    free          = !out_valid_r || out_ready;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (free) begin
      out_valid_nxt = 1'b0;
      if (cnt_r != '0) begin
        // one nibble per beat, most significant first
        out_valid_nxt           = 1'b1;
        out_data_nxt.status     = ST_OK;
        out_data_nxt.hex_char   = nib_to_hex(sh_r[NONCE_BITS-1 -: 4]);
        out_data_nxt.char_valid = 1'b1;
        out_data_nxt.last       = (cnt_r == CNT_W'(1));
        sh_nxt                  = sh_r << 4;
        cnt_nxt                 = cnt_r - CNT_W'(1);
      end else if (req.single) begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.status     = req.status;
        out_data_nxt.hex_char   = 7'h00;
        out_data_nxt.char_valid = 1'b0;
        out_data_nxt.last       = 1'b1;
      end
    end
    if (req.load) begin
      sh_nxt  = req.nonce;
      cnt_nxt = NCHARS_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign st.busy   = (cnt_r != '0);
  assign st.free   = free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/nc_check.sv]
// ----------------------------------------------------------------------------
// nc_check
// collects echoed characters and compares them a nibble at a time
// ----------------------------------------------------------------------------
`default_nettype none

module nc_check (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nc_pkg::nc_chk_req_t  req,
  output logic                     fail
);
  import nc_pkg::*;

  logic [NONCE_BITS-1:0] cmp_r, cmp_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  bad_r, bad_nxt;
  logic [4:0]            dec;

  always_comb begin
    dec     = hex_to_nib(req.echo_char);
    cmp_nxt = cmp_r;
    cnt_nxt = cnt_r;
    bad_nxt = bad_r;
    if (req.echo) begin
      if (cnt_r >= NCHARS_C) begin
        bad_nxt = 1'b1;
      end else begin
        if (!dec[4] || dec[3:0] != cmp_r[NONCE_BITS-1 -: 4]) begin
          bad_nxt = 1'b1;
        end
        // rotate so the next expected nibble sits on top
        cmp_nxt = {cmp_r[NONCE_BITS-5:0], cmp_r[NONCE_BITS-1 -: 4]};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    // bad char, wrong length or any nibble mismatch
    fail = bad_nxt || (cnt_nxt != NCHARS_C);
    if (req.load) begin
      cmp_nxt = req.nonce;
      cnt_nxt = '0;
      bad_nxt = 1'b0;
    end else if (req.echo && req.last) begin
      cnt_nxt = '0;
      bad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_r <= cmp_nxt;
  end

endmodule

`default_nettype wire

[rtl/nc_sva.sv]
// ----------------------------------------------------------------------------
// nc_sva
// port level checker for the nonce challenge engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "nonce_challenge_rate_limited_defines.svh"

module nc_sva (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire nc_pkg::nc_out_t  out_data
);
  import nc_pkg::*;

  // stalled beat holds
  `NC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // characters only come with an ok status
  `NC_ASSERT_IMP(a_char_ok, clk, rst_n, out_valid && out_data.char_valid, out_data.status == ST_OK, "character beat without ok status")

  // status beats are single and carry no character
  `NC_ASSERT_IMP(a_status_beat, clk, rst_n, out_valid && !out_data.char_valid, out_data.last && out_data.hex_char == 7'h00, "status beat malformed")

  // emitted characters are lowercase hex
  `NC_ASSERT_IMP(a_hex_range, clk, rst_n, out_valid && out_data.char_valid, (out_data.hex_char >= 7'h30 && out_data.hex_char <= 7'h39) || (out_data.hex_char >= 7'h61 && out_data.hex_char <= 7'h66), "emitted character not lowercase hex")

  // no input taken while a character run is mid stream
  `NC_ASSERT_IMP(a_run_blocks, clk, rst_n, out_valid && out_data.char_valid && !out_data.last, !in_ready, "input accepted during character run")

endmodule

bind nonce_challenge_rate_limited nc_sva u_nc_sva (.*);

`default_nettype wire
